>>> src/band_energy_beat_detector_macros.svh
// Assertion macros for the band energy beat detector checker.
// No dependencies; the user supplies clk_i and rst_ni in scope.
`ifndef BAND_ENERGY_BEAT_DETECTOR_MACROS_SVH
`define BAND_ENERGY_BEAT_DETECTOR_MACROS_SVH

// clocked check, masked while reset is held
`define BED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define BED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/bed_pkg.sv
// Shared constants, types and helpers of the band energy beat detector.
// No dependencies.
`timescale 1ns / 1ps

package bed_pkg;

  localparam int unsigned FFT_POINTS    = 2048;
  localparam int unsigned HISTORY_DEPTH = 64;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned BIN_W    = 11;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned IDX_W    = 3;

  // bin position stops counting at the half spectrum plus one
  localparam int unsigned MAX_BIN = FFT_POINTS / 2 + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_BIN + 1);
  localparam int unsigned CMP_W   = (CNT_W > BIN_W) ? CNT_W : BIN_W;

  localparam int unsigned PTR_W    = $clog2(HISTORY_DEPTH);
  localparam int unsigned RT_W     = SUM_W + $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LHS_MULT = 16 * HISTORY_DEPTH;
  localparam int unsigned LHS_W    = SUM_W + $clog2(LHS_MULT + 1);
  localparam int unsigned RHS_W    = THR_W + RT_W;
  localparam int unsigned BT_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned OUTST_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [BIN_W-1:0] KICK_FIRST_RST  = BIN_W'(0);
  localparam logic [BIN_W-1:0] KICK_END_RST    = BIN_W'(6);
  localparam logic [BIN_W-1:0] SNARE_FIRST_RST = BIN_W'(9);
  localparam logic [BIN_W-1:0] SNARE_END_RST   = BIN_W'(13);
  localparam logic [BIN_W-1:0] HAT_FIRST_RST   = BIN_W'(139);
  localparam logic [BIN_W-1:0] HAT_END_RST     = BIN_W'(371);
  localparam logic [THR_W-1:0] THRESHOLD_RST   = THR_W'(24);

  typedef enum logic [IDX_W-1:0] {
    CFG_KICK_FIRST  = 3'd0,
    CFG_KICK_END    = 3'd1,
    CFG_SNARE_FIRST = 3'd2,
    CFG_SNARE_END   = 3'd3,
    CFG_HAT_FIRST   = 3'd4,
    CFG_HAT_END     = 3'd5,
    CFG_THRESHOLD   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [BIN_W-1:0] first_bin;
    logic [BIN_W-1:0] end_bin;
  } band_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [MAG_W-1:0] mag;
  } mag_word_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] kick;
    logic [SUM_W-1:0] snare;
    logic [SUM_W-1:0] hat;
  } frame_sums_t;

  typedef struct packed {
    logic             kick_beat;
    logic             snare_beat;
    logic             hihat_beat;
    logic [SUM_W-1:0] energy;
  } result_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> src/bed_mag.sv
// Input register and squared magnitude stage.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_mag (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic signed [bed_pkg::SAMPLE_W-1:0] bin_real_i,
  input  logic signed [bed_pkg::SAMPLE_W-1:0] bin_imag_i,
  input  logic                              last_bin_i,
  output bed_pkg::mag_word_t                mag_o
);

  logic                               valid_q;
  logic                               last_q;
  logic signed [bed_pkg::SAMPLE_W-1:0] re_q, im_q;
  logic signed [bed_pkg::MAG_W-1:0]    sq_re, sq_im;
  logic [bed_pkg::MAG_W-1:0]           mag_d;
  logic                                mag_valid_q;
  logic                                mag_last_q;
  logic [bed_pkg::MAG_W-1:0]           mag_q;

  // each square is at most 2^30, so the sum fits 32 bits unsigned
  always_comb begin
    sq_re = re_q * re_q;
    sq_im = im_q * im_q;
    mag_d = unsigned'(sq_re) + unsigned'(sq_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      mag_valid_q <= 1'b0;
    end else begin
      valid_q     <= accept_i;
      mag_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      re_q   <= bin_real_i;
      im_q   <= bin_imag_i;
      last_q <= last_bin_i;
    end
    mag_last_q <= last_q;
    mag_q      <= mag_d;
  end

  assign mag_o = {mag_valid_q, mag_last_q, mag_q};

endmodule

>>> src/bed_accum.sv
// Per-band energy accumulation over one frame, with the bin position counter.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bed_pkg::band_cfg_t   kick_cfg_i,
  input  bed_pkg::band_cfg_t   snare_cfg_i,
  input  bed_pkg::band_cfg_t   hat_cfg_i,
  input  bed_pkg::mag_word_t   mag_i,
  output bed_pkg::frame_sums_t frame_o
);

  logic [bed_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [bed_pkg::SUM_W-1:0] kick_q, snare_q, hat_q;
  logic [bed_pkg::SUM_W-1:0] kick_n, snare_n, hat_n;
  logic [bed_pkg::SUM_W-1:0] mag_ext;
  logic                      counting;
  logic                      frame_valid_q;
  logic [bed_pkg::SUM_W-1:0] frame_kick_q, frame_snare_q, frame_hat_q;

  function automatic logic in_band(input logic [bed_pkg::CNT_W-1:0] pos,
                                   input bed_pkg::band_cfg_t band);
    logic [bed_pkg::CMP_W-1:0] p, f, e;
    p = bed_pkg::CMP_W'(pos);
    f = bed_pkg::CMP_W'(band.first_bin);
    e = bed_pkg::CMP_W'(band.end_bin);
    return (p >= f) && (p < e);
  endfunction

  always_comb begin
    mag_ext  = bed_pkg::SUM_W'(mag_i.mag);
    counting = cnt_q < bed_pkg::CNT_W'(bed_pkg::MAX_BIN);
    kick_n   = kick_q;
    snare_n  = snare_q;
    hat_n    = hat_q;
    cnt_d    = cnt_q;
    if (counting) begin
      if (in_band(cnt_q, kick_cfg_i))  kick_n  = bed_pkg::sat_add(kick_q, mag_ext);
      if (in_band(cnt_q, snare_cfg_i)) snare_n = bed_pkg::sat_add(snare_q, mag_ext);
      if (in_band(cnt_q, hat_cfg_i))   hat_n   = bed_pkg::sat_add(hat_q, mag_ext);
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      kick_q        <= '0;
      snare_q       <= '0;
      hat_q         <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      frame_valid_q <= mag_i.valid && mag_i.last;
      if (mag_i.valid) begin
        if (mag_i.last) begin
          cnt_q   <= '0;
          kick_q  <= '0;
          snare_q <= '0;
          hat_q   <= '0;
        end else begin
          cnt_q   <= cnt_d;
          kick_q  <= kick_n;
          snare_q <= snare_n;
          hat_q   <= hat_n;
        end
      end
    end
  end

  // closing sums of the frame, last bin included
  always_ff @(posedge clk_i) begin
    if (mag_i.valid && mag_i.last) begin
      frame_kick_q  <= kick_n;
      frame_snare_q <= snare_n;
      frame_hat_q   <= hat_n;
    end
  end

  assign frame_o = {frame_valid_q, frame_kick_q, frame_snare_q, frame_hat_q};

endmodule

>>> src/bed_decide.sv
// Beat decision against the mean of past frame energies, and the history ring.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_decide (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bed_pkg::THR_W-1:0]  threshold_i,
  input  bed_pkg::frame_sums_t       frame_i,
  output logic                       push_o,
  output bed_pkg::result_t           result_o
);

  logic [bed_pkg::SUM_W-1:0] ring_mem [bed_pkg::HISTORY_DEPTH];
  logic [bed_pkg::SUM_W-1:0] rd_q;
  logic [bed_pkg::PTR_W-1:0] ptr_q, ptr_d;
  logic                      wrapped_q;
  logic [bed_pkg::RT_W-1:0]  rt_q, rt_d;
  logic [bed_pkg::SUM_W-1:0] total, oldest;
  logic                      ptr_at_end;

  logic [bed_pkg::BT_W-1:0]  lhs_k_d, lhs_s_d, lhs_h_d, rhs_d;
  logic [bed_pkg::BT_W-1:0]  lhs_k_q, lhs_s_q, lhs_h_q, rhs_q;
  logic [bed_pkg::SUM_W-1:0] total_q;
  logic                      valid_q;

  always_comb begin
    total      = bed_pkg::sat_add(bed_pkg::sat_add(frame_i.kick, frame_i.snare), frame_i.hat);
    // entries not yet written since reset count as one; writes go in order
    oldest     = wrapped_q ? rd_q : bed_pkg::SUM_W'(1);
    ptr_at_end = ptr_q == bed_pkg::PTR_W'(bed_pkg::HISTORY_DEPTH - 1);
    ptr_d      = ptr_q;
    rt_d       = rt_q;
    if (frame_i.valid) begin
      ptr_d = ptr_at_end ? '0 : ptr_q + 1'b1;
      rt_d  = rt_q - bed_pkg::RT_W'(oldest) + bed_pkg::RT_W'(total);
    end
    lhs_k_d = bed_pkg::BT_W'(frame_i.kick) * bed_pkg::BT_W'(bed_pkg::LHS_MULT);
    lhs_s_d = bed_pkg::BT_W'(frame_i.snare) * bed_pkg::BT_W'(bed_pkg::LHS_MULT);
    lhs_h_d = bed_pkg::BT_W'(frame_i.hat) * bed_pkg::BT_W'(bed_pkg::LHS_MULT);
    rhs_d   = bed_pkg::BT_W'(bed_pkg::RHS_W'(threshold_i) * bed_pkg::RHS_W'(rt_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      rt_q      <= bed_pkg::RT_W'(bed_pkg::HISTORY_DEPTH);
      valid_q   <= 1'b0;
    end else begin
      valid_q <= frame_i.valid;
      ptr_q   <= ptr_d;
      rt_q    <= rt_d;
      if (frame_i.valid && ptr_at_end) wrapped_q <= 1'b1;
    end
  end

  // write at the current slot, prefetch the slot the next frame will retire
  always_ff @(posedge clk_i) begin
    if (frame_i.valid) ring_mem[ptr_q] <= total;
    rd_q <= ring_mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      lhs_k_q <= lhs_k_d;
      lhs_s_q <= lhs_s_d;
      lhs_h_q <= lhs_h_d;
      rhs_q   <= rhs_d;
      total_q <= total;
    end
  end

  assign push_o              = valid_q;
  assign result_o.kick_beat  = lhs_k_q > rhs_q;
  assign result_o.snare_beat = lhs_s_q > rhs_q;
  assign result_o.hihat_beat = lhs_h_q > rhs_q;
  assign result_o.energy     = total_q;

endmodule

>>> src/bed_out_fifo.sv
// Result queue between the decision stage and the output channel.
// Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bed_pkg::result_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bed_pkg::result_t data_o
);

  bed_pkg::result_t              mem_q [bed_pkg::FIFO_DEPTH];
  logic [bed_pkg::FIFO_AW-1:0]   wr_q, rd_q;
  logic [bed_pkg::OUTST_W-1:0]   count_q;
  logic                          pop;

  function automatic logic [bed_pkg::FIFO_AW-1:0] inc_ptr(
      input logic [bed_pkg::FIFO_AW-1:0] p);
    return (p == bed_pkg::FIFO_AW'(bed_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  // upstream credit keeps pushes off a full queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= inc_ptr(wr_q);
      if (pop)    rd_q <= inc_ptr(rd_q);
      unique case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> src/band_energy_beat_detector.sv
// Band energy beat detector: takes one FFT bin per cycle, sums squared
// magnitude over three configurable bands and, on the last bin of a frame,
// flags a beat per band when its energy beats threshold/16 times the mean of
// the last 64 frame energies. A result passes, after the last bin is taken,
// through input register, squares, band accumulate, history ring and
// products, and compare into an eight-deep result queue. One bin is accepted
// every cycle; in_ready_o drops only while eight results are outstanding
// in the pipeline and queue. The 64-entry history ring is a memory read one
// frame ahead; entries not yet written read as one, with no clearing pass.
// Depends on bed_pkg, bed_mag, bed_accum, bed_decide and bed_out_fifo.
`timescale 1ns / 1ps

module band_energy_beat_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bed_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [bed_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bed_pkg::SAMPLE_W-1:0] bin_real_i,
  input  logic signed [bed_pkg::SAMPLE_W-1:0] bin_imag_i,
  input  logic                                last_bin_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kick_beat_o,
  output logic                                snare_beat_o,
  output logic                                hihat_beat_o,
  output logic [bed_pkg::SUM_W-1:0]           frame_energy_o
);

  bed_pkg::band_cfg_t           kick_cfg_q, snare_cfg_q, hat_cfg_q;
  logic [bed_pkg::THR_W-1:0]    thr_q;
  logic [bed_pkg::OUTST_W-1:0]  outst_q;
  logic                         in_accept, out_accept;
  bed_pkg::mag_word_t           mag;
  bed_pkg::frame_sums_t         frame;
  logic                         push;
  bed_pkg::result_t             result, head;

  assign in_ready_o = outst_q < bed_pkg::OUTST_W'(bed_pkg::FIFO_DEPTH);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_accept = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_cfg_q.first_bin  <= bed_pkg::KICK_FIRST_RST;
      kick_cfg_q.end_bin    <= bed_pkg::KICK_END_RST;
      snare_cfg_q.first_bin <= bed_pkg::SNARE_FIRST_RST;
      snare_cfg_q.end_bin   <= bed_pkg::SNARE_END_RST;
      hat_cfg_q.first_bin   <= bed_pkg::HAT_FIRST_RST;
      hat_cfg_q.end_bin     <= bed_pkg::HAT_END_RST;
      thr_q                 <= bed_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (bed_pkg::cfg_idx_e'(cfg_index_i))
        bed_pkg::CFG_KICK_FIRST:  kick_cfg_q.first_bin  <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_KICK_END:    kick_cfg_q.end_bin    <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_SNARE_FIRST: snare_cfg_q.first_bin <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_SNARE_END:   snare_cfg_q.end_bin   <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_HAT_FIRST:   hat_cfg_q.first_bin   <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_HAT_END:     hat_cfg_q.end_bin     <= cfg_wdata_i[bed_pkg::BIN_W-1:0];
        bed_pkg::CFG_THRESHOLD:   thr_q                 <= cfg_wdata_i[bed_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // results owed: last bins taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      unique case ({in_accept && last_bin_i, out_accept})
        2'b10:   outst_q <= outst_q + 1'b1;
        2'b01:   outst_q <= outst_q - 1'b1;
        default: outst_q <= outst_q;
      endcase
    end
  end

  bed_mag u_mag (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .bin_real_i (bin_real_i),
    .bin_imag_i (bin_imag_i),
    .last_bin_i (last_bin_i),
    .mag_o      (mag)
  );

  bed_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kick_cfg_i  (kick_cfg_q),
    .snare_cfg_i (snare_cfg_q),
    .hat_cfg_i   (hat_cfg_q),
    .mag_i       (mag),
    .frame_o     (frame)
  );

  bed_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .frame_i     (frame),
    .push_o      (push),
    .result_o    (result)
  );

  bed_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head)
  );

  assign kick_beat_o    = head.kick_beat;
  assign snare_beat_o   = head.snare_beat;
  assign hihat_beat_o   = head.hihat_beat;
  assign frame_energy_o = head.energy;

endmodule

>>> src/bed_checker.sv
// Port-level checks of the band energy beat detector, bound to the top level.
// Depends on bed_pkg and band_energy_beat_detector_macros.svh.
`timescale 1ns / 1ps
`include "band_energy_beat_detector_macros.svh"

module bed_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic last_bin_i,
  input logic out_valid_o,
  input logic out_ready_i
);

  logic [bed_pkg::OUTST_W:0] pend_q;
  logic                      in_last, out_take;

  assign in_last  = in_valid_i && in_ready_o && last_bin_i;
  assign out_take = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + (bed_pkg::OUTST_W + 1)'(in_last)
                       - (bed_pkg::OUTST_W + 1)'(out_take);
    end
  end

  // the quiet output is checked on the edge after reset is sampled low
  `BED_ASSERT(out_word_held, out_valid_o && !out_ready_i |=> out_valid_o, "word dropped in stall")
  `BED_ASSERT_ALWAYS(quiet_in_reset, !rst_ni |=> !out_valid_o, "result word shown in reset")
  `BED_ASSERT(result_needs_frame, out_valid_o |-> pend_q != '0, "result word with no frame")
  `BED_ASSERT(stall_needs_backlog, !in_ready_o |-> pend_q != '0, "stall with no results owed")

endmodule

bind band_energy_beat_detector bed_checker u_bed_checker (.*);

>>> tb/tb_band_energy_beat_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for band_energy_beat_detector: streams FFT bin words,
// predicts beat flags and frame energy per frame, checks every result word.
// Depends on bed_pkg and the band_energy_beat_detector RTL.

module tb_band_energy_beat_detector;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LATENCY     = 5;
  // no register behind this index
  localparam logic [bed_pkg::IDX_W-1:0] CFG_NONE = bed_pkg::IDX_W'(7);
  localparam logic [63:0] ENERGY_MAX = (64'd1 << bed_pkg::SUM_W) - 64'd1;

  typedef enum int {BAND_KICK, BAND_SNARE, BAND_HAT} band_e;

  typedef struct packed {
    logic signed [bed_pkg::SAMPLE_W-1:0] re;
    logic signed [bed_pkg::SAMPLE_W-1:0] im;
    logic                                last;
  } bin_word_t;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                cfg_we_i    = 1'b0;
  logic [bed_pkg::IDX_W-1:0]           cfg_index_i = '0;
  logic [bed_pkg::CFG_W-1:0]           cfg_wdata_i = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic signed [bed_pkg::SAMPLE_W-1:0] bin_real_i  = '0;
  logic signed [bed_pkg::SAMPLE_W-1:0] bin_imag_i  = '0;
  logic                                last_bin_i  = 1'b0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic                                kick_beat_o;
  logic                                snare_beat_o;
  logic                                hihat_beat_o;
  logic [bed_pkg::SUM_W-1:0]           frame_energy_o;

  band_energy_beat_detector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .bin_real_i     (bin_real_i),
    .bin_imag_i     (bin_imag_i),
    .last_bin_i     (last_bin_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kick_beat_o    (kick_beat_o),
    .snare_beat_o   (snare_beat_o),
    .hihat_beat_o   (hihat_beat_o),
    .frame_energy_o (frame_energy_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [bed_pkg::BIN_W-1:0] band_first [3];
  logic [bed_pkg::BIN_W-1:0] band_end [3];
  logic [bed_pkg::THR_W-1:0] thr_sixteenths;
  int unsigned               bin_pos;
  logic [63:0]               band_energy [3];
  logic [63:0]               history [bed_pkg::HISTORY_DEPTH];
  int unsigned               hist_ptr;
  logic [63:0]               hist_sum;

  bed_pkg::result_t frame_results_q [$];
  bin_word_t        bin_words_q [$];

  int unsigned n_queued    = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_results   = 0;
  int unsigned n_beats     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_errors    = 0;
  int unsigned cycle_count = 0;

  int unsigned      gap_max    = 0;
  int unsigned      gap_left   = 0;
  int unsigned      burst_left = 0;
  int unsigned      sink_mode  = 0;
  int unsigned      ready_run  = 0;
  logic             ready_next;
  bin_word_t        drive_word;
  bin_word_t        taken_word;
  bed_pkg::result_t want;

  function automatic void reset_model();
    int unsigned i;
    band_first[BAND_KICK]  = bed_pkg::KICK_FIRST_RST;
    band_end[BAND_KICK]    = bed_pkg::KICK_END_RST;
    band_first[BAND_SNARE] = bed_pkg::SNARE_FIRST_RST;
    band_end[BAND_SNARE]   = bed_pkg::SNARE_END_RST;
    band_first[BAND_HAT]   = bed_pkg::HAT_FIRST_RST;
    band_end[BAND_HAT]     = bed_pkg::HAT_END_RST;
    thr_sixteenths = bed_pkg::THRESHOLD_RST;
    bin_pos = 0;
    band_energy = '{64'd0, 64'd0, 64'd0};
    for (i = 0; i < bed_pkg::HISTORY_DEPTH; i++) history[i] = 64'd1;
    hist_ptr = 0;
    hist_sum = 64'(bed_pkg::HISTORY_DEPTH);
  endfunction

  function automatic logic [63:0] clamp(logic [63:0] v);
    return (v > ENERGY_MAX) ? ENERGY_MAX : v;
  endfunction

  // energy * 16 * depth against threshold * history sum, both fit in 64 bits
  function automatic logic beats(logic [63:0] e);
    return (e * 64'(16 * bed_pkg::HISTORY_DEPTH)) > (64'(thr_sixteenths) * hist_sum);
  endfunction

  function automatic void take_bin(bin_word_t w);
    longint           sr;
    longint           si;
    logic [63:0]      mag;
    logic [63:0]      total;
    int               b;
    bed_pkg::result_t r;
    sr  = longint'($signed(w.re));
    si  = longint'($signed(w.im));
    mag = 64'(sr * sr) + 64'(si * si);
    // position sticks at the half spectrum plus one, so later bins add nothing
    if (bin_pos < bed_pkg::MAX_BIN) begin
      for (b = 0; b < 3; b++) begin
        if (bin_pos >= band_first[b] && bin_pos < band_end[b])
          band_energy[b] = clamp(band_energy[b] + mag);
      end
      bin_pos++;
    end
    if (w.last) begin
      total = clamp(clamp(band_energy[BAND_KICK] + band_energy[BAND_SNARE])
                    + band_energy[BAND_HAT]);
      r.kick_beat  = beats(band_energy[BAND_KICK]);
      r.snare_beat = beats(band_energy[BAND_SNARE]);
      r.hihat_beat = beats(band_energy[BAND_HAT]);
      r.energy     = total[bed_pkg::SUM_W-1:0];
      frame_results_q.push_back(r);
      hist_sum = hist_sum - history[hist_ptr] + total;
      history[hist_ptr] = total;
      hist_ptr = (hist_ptr + 1) % bed_pkg::HISTORY_DEPTH;
      bin_pos = 0;
      band_energy = '{64'd0, 64'd0, 64'd0};
    end
  endfunction

  task automatic write_reg(logic [bed_pkg::IDX_W-1:0] idx, logic [bed_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      bed_pkg::CFG_KICK_FIRST:  band_first[BAND_KICK] = val;
      bed_pkg::CFG_KICK_END:    band_end[BAND_KICK] = val;
      bed_pkg::CFG_SNARE_FIRST: band_first[BAND_SNARE] = val;
      bed_pkg::CFG_SNARE_END:   band_end[BAND_SNARE] = val;
      bed_pkg::CFG_HAT_FIRST:   band_first[BAND_HAT] = val;
      bed_pkg::CFG_HAT_END:     band_end[BAND_HAT] = val;
      bed_pkg::CFG_THRESHOLD:   thr_sixteenths = val[bed_pkg::THR_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_bands(int unsigned kf, int unsigned ke, int unsigned sf,
                           int unsigned se, int unsigned hf, int unsigned he,
                           logic [bed_pkg::CFG_W-1:0] thr);
    write_reg(bed_pkg::CFG_KICK_FIRST, bed_pkg::CFG_W'(kf));
    write_reg(bed_pkg::CFG_KICK_END, bed_pkg::CFG_W'(ke));
    write_reg(bed_pkg::CFG_SNARE_FIRST, bed_pkg::CFG_W'(sf));
    write_reg(bed_pkg::CFG_SNARE_END, bed_pkg::CFG_W'(se));
    write_reg(bed_pkg::CFG_HAT_FIRST, bed_pkg::CFG_W'(hf));
    write_reg(bed_pkg::CFG_HAT_END, bed_pkg::CFG_W'(he));
    write_reg(bed_pkg::CFG_THRESHOLD, thr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void push_word(int re, int im, logic last);
    bin_word_t w;
    w.re   = bed_pkg::SAMPLE_W'(re);
    w.im   = bed_pkg::SAMPLE_W'(im);
    w.last = last;
    bin_words_q.push_back(w);
    n_queued++;
  endfunction

  function automatic int rand_sample(int unsigned loud);
    int v;
    case (loud)
      0: v = 0;
      1: v = int'($urandom_range(0, 6)) - 3;
      2: v = int'($urandom_range(0, 510)) - 255;
      default: begin
        case ($urandom_range(0, 7))
          0: v = -32768;
          1: v = 32767;
          default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void queue_frame(int unsigned len, int unsigned loud);
    int unsigned i;
    for (i = 0; i < len; i++)
      push_word(rand_sample(loud), rand_sample(loud), i == len - 1);
  endfunction

  // frames of random length and loudness, so history swings and beats come and go
  function automatic void random_frames(int unsigned n_words, int unsigned max_len);
    int unsigned cnt;
    int unsigned len;
    int unsigned pick;
    cnt = 0;
    while (cnt < n_words) begin
      len  = $urandom_range(1, max_len);
      pick = $urandom_range(0, 9);
      queue_frame(len, (pick == 0) ? 0 : (pick < 4) ? 1 : (pick < 7) ? 2 : 3);
      cnt += len;
    end
  endfunction

  // sender holds off until every word is taken and every result is back
  task automatic drain();
    while (n_accepted != n_queued || frame_results_q.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  // sender: bursts of words with random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        taken_word.re   = bin_real_i;
        taken_word.im   = bin_imag_i;
        taken_word.last = last_bin_i;
        take_bin(taken_word);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0 || bin_words_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          drive_word = bin_words_q.pop_front();
          bin_real_i <= drive_word.re;
          bin_imag_i <= drive_word.im;
          last_bin_i <= drive_word.last;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: always ready, random stalls, or long runs of either
  always @(posedge clk_i) begin
    if (ready_run != 0) begin
      ready_run--;
    end else begin
      case (sink_mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        default: begin
          ready_next = 1'($urandom_range(0, 1));
          ready_run  = $urandom_range(0, 11);
        end
      endcase
      out_ready_i <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        $error("result word with no frame pending, frame_energy %0d", frame_energy_o);
        n_errors++;
      end else begin
        want = frame_results_q.pop_front();
        if (kick_beat_o !== want.kick_beat) begin
          $error("kick_beat: expected %0b, got %0b", want.kick_beat, kick_beat_o);
          n_errors++;
        end
        if (snare_beat_o !== want.snare_beat) begin
          $error("snare_beat: expected %0b, got %0b", want.snare_beat, snare_beat_o);
          n_errors++;
        end
        if (hihat_beat_o !== want.hihat_beat) begin
          $error("hihat_beat: expected %0b, got %0b", want.hihat_beat, hihat_beat_o);
          n_errors++;
        end
        if (frame_energy_o !== want.energy) begin
          $error("frame_energy: expected %0d, got %0d", want.energy, frame_energy_o);
          n_errors++;
        end
        n_results++;
        n_beats += want.kick_beat + want.snare_beat + want.hihat_beat;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_results_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: full-scale corners across kick and snare, then a tiny frame
    push_word(-32768, -32768, 1'b0);
    push_word(32767, 32767, 1'b0);
    push_word(-32768, 32767, 1'b0);
    push_word(1, -1, 1'b0);
    push_word(0, 0, 1'b0);
    push_word(-1, 0, 1'b0);
    push_word(100, -100, 1'b0);
    push_word(-100, 100, 1'b0);
    push_word(100, 100, 1'b0);
    push_word(32767, -32768, 1'b0);
    push_word(-5, 7, 1'b0);
    push_word(5, -7, 1'b0);
    push_word(-5, -7, 1'b0);
    push_word(3, 3, 1'b1);
    push_word(1, 0, 1'b1);
    drain();

    // zero threshold: any nonzero band beats, a silent one does not
    set_bands(0, 6, 9, 13, 139, 371, 11'd0);
    push_word(0, 0, 1'b0);
    push_word(0, 1, 1'b1);
    push_word(0, 0, 1'b1);
    drain();

    // overlapping bands
    set_bands(0, 4, 2, 8, 5, 12, 11'd24);
    gap_max   = 6;
    sink_mode = 1;
    random_frames(200, 16);
    drain();

    // full spectrum, reversed and empty bands
    set_bands(0, 1025, 1025, 0, 7, 7, 11'd255);
    write_reg(CFG_NONE, 11'h7FF);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_max   = 3;
    sink_mode = 2;
    queue_frame(40, 2);
    random_frames(100, 12);
    drain();

    // silence the whole history so its sum reaches zero
    set_bands(5, 5, 1025, 1025, 12, 3, 11'd24);
    gap_max   = 0;
    sink_mode = 0;
    repeat (bed_pkg::HISTORY_DEPTH) queue_frame($urandom_range(1, 3), 3);
    drain();

    set_bands(0, 3, 1, 5, 3, 9, 11'd1);
    gap_max   = 6;
    sink_mode = 2;
    random_frames(120, 10);
    drain();

    // threshold register keeps only its low byte
    set_bands(1, 3, 0, 16, 4, 6, 11'h710);
    gap_max   = 6;
    sink_mode = 1;
    random_frames(120, 20);
    drain();

    $display("%0d bin words in, %0d frame results checked, %0d beat flags, %0d writes",
             n_accepted, n_results, n_beats, n_writes);
    $display("covered overlapping, empty, reversed and full bands, zero history and threshold");
    if (n_errors == 0 && frame_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
